[sv/spf_pkg.sv]
// Package for the scanline span fill block: shared widths and the reset clip edge.
// Used by scanline_polygon_span_fill and its testbench; depends on nothing.
package spf_pkg;
  localparam int unsigned XW = 12;
  localparam logic [XW-1:0] CLIP_RESET = 12'd1263;
endpackage

[sv/spf_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Used by scanline_polygon_span_fill; depends on nothing.
module spf_div #(
  parameter int NW = 34,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);
  logic [NW-1:0] n_r [NW+1];
  logic [DW-1:0] d_r [NW+1];
  logic [DW:0]   rem_r [NW+1];
  logic [NW-1:0] q_r [NW+1];

  always_comb begin
    n_r[0]   = num;
    d_r[0]   = den;
    rem_r[0] = '0;
    q_r[0]   = '0;
  end

  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [DW+1:0] tr;
    logic [DW+1:0] df;
    logic [DW-1:0] d_nxt;
    logic [DW:0]   rem_nxt;
    logic [NW-1:0] q_nxt;
    always_comb begin
      tr = {rem_r[s], n_r[s][NW-1-s]};
      df = tr - {2'b00, d_r[s]};
      d_nxt = d_r[s];
      if (!df[DW+1]) begin
        rem_nxt = df[DW:0];
        q_nxt = q_r[s] | (NW'(1) << (NW-1-s));
      end else begin
        rem_nxt = tr[DW:0];
        q_nxt = q_r[s];
      end
    end
    logic [NW-1:0] nr_r;
    logic [DW-1:0] dr_r;
    logic [DW:0]   rr_r;
    logic [NW-1:0] qr_r;
    always_ff @(posedge clk) begin
      nr_r <= n_r[s];
      dr_r <= d_nxt;
      rr_r <= rem_nxt;
      qr_r <= q_nxt;
    end
    always_comb begin
      n_r[s+1]   = nr_r;
      d_r[s+1]   = dr_r;
      rem_r[s+1] = rr_r;
      q_r[s+1]   = qr_r;
    end
  end

  assign quo = q_r[NW];
endmodule

[sv/scanline_polygon_span_fill.sv]
// Top level of the scanline span fill: edge setup, four pipelined dividers, sort, clamp.
// Depends on spf_pkg and spf_div.
//
// channel | ports                                  | handshake
// input   | start, busy, in_vertex*, in_corner_count, in_row | start & !busy
// result  | out_valid, out_*                       | strobe, one cycle, no stall
// config  | cfg_valid, cfg_ready, cfg_clip_right_edge | valid & ready
//
// One item may enter in every cycle; busy is always low. The result of an item
// is strobed once it has passed three setup stages, 2*COORD_BITS + 3 divider
// stages, three sort stages and the output register. Reset clears only the valid
// and crossing flags and the clip register. As the receiver cannot stall,
// nothing in the pipeline ever waits.
module scanline_polygon_span_fill #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [COORD_BITS-1:0] in_vertex0_x,
  input  logic signed [COORD_BITS-1:0] in_vertex0_y,
  input  logic signed [COORD_BITS-1:0] in_vertex1_x,
  input  logic signed [COORD_BITS-1:0] in_vertex1_y,
  input  logic signed [COORD_BITS-1:0] in_vertex2_x,
  input  logic signed [COORD_BITS-1:0] in_vertex2_y,
  input  logic signed [COORD_BITS-1:0] in_vertex3_x,
  input  logic signed [COORD_BITS-1:0] in_vertex3_y,
  input  logic [2:0]            in_corner_count,
  input  logic [11:0]           in_row,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [11:0]           cfg_clip_right_edge,
  output logic                  out_valid,
  output logic                  out_first_span_valid,
  output logic [11:0]           out_first_span_start,
  output logic [11:0]           out_first_span_end,
  output logic                  out_second_span_valid,
  output logic [11:0]           out_second_span_start,
  output logic [11:0]           out_second_span_end
);
  // Widths: dy and dx take CW+1 bits, the product (row - ya)*dx about 2CW+2 bits.
  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;          // |dy|
  localparam int PW  = 2*CW + 3;        // |2*num + den|, unsigned
  localparam int XEW = 2*CW + 4;        // signed crossing width
  localparam int DL  = PW;              // divider latency
  localparam int HD  = DL + 2;          // stage 1 to divider output
  localparam logic signed [XEW-1:0] XFILL = {1'b0, {(XEW-1){1'b1}}};

  logic [11:0] clip_r;
  assign cfg_ready = 1'b1;
  assign busy = 1'b0;
  always_ff @(posedge clk) begin
    if (!rst_n) clip_r <= spf_pkg::CLIP_RESET;
    else if (cfg_valid) clip_r <= cfg_clip_right_edge;
  end

  logic signed [CW-1:0] vx [4];
  logic signed [CW-1:0] vy [4];
  assign vx[0] = in_vertex0_x; assign vy[0] = in_vertex0_y;
  assign vx[1] = in_vertex1_x; assign vy[1] = in_vertex1_y;
  assign vx[2] = in_vertex2_x; assign vy[2] = in_vertex2_y;
  assign vx[3] = in_vertex3_x; assign vy[3] = in_vertex3_y;

  logic quad;
  assign quad = (in_corner_count >= 3'd4);

  // Stage 1: per edge, crossing test, differences and the start corner's x.
  logic        acc;
  assign acc = start && !busy;
  logic                 s1_v_r;
  logic [3:0]           s1_hit_r;
  logic signed [CW+1:0] s1_dyr_r [4];   // row - ya
  logic signed [CW:0]   s1_dx_r  [4];
  logic signed [CW:0]   s1_dy_r  [4];
  logic signed [CW-1:0] s1_xa_r  [4];

  for (genvar e = 0; e < 4; e++) begin : g_e1
    // Edge e runs from corner j to corner i, in the model's order.
    localparam int I = e;
    logic signed [CW-1:0] xa, ya, xb, yb;
    logic hit;
    always_comb begin
      if (e == 0) begin
        xa = quad ? vx[3] : vx[2];
        ya = quad ? vy[3] : vy[2];
      end else begin
        xa = vx[e-1];
        ya = vy[e-1];
      end
      xb = vx[I];
      yb = vy[I];
      hit = ((ya <= $signed({1'b0, in_row})) != (yb <= $signed({1'b0, in_row})));
      if (e == 3 && !quad) hit = 1'b0;
    end
    always_ff @(posedge clk) begin
      s1_hit_r[e] <= hit;
      s1_dyr_r[e] <= $signed({2'b00, in_row}) - (CW+2)'(ya);
      s1_dx_r[e]  <= (CW+1)'(xb) - (CW+1)'(xa);
      s1_dy_r[e]  <= (CW+1)'(yb) - (CW+1)'(ya);
      s1_xa_r[e]  <= xa;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else s1_v_r <= acc;
  end

  // Stage 2: product and its magnitude, |dy|, and the sign of the numerator
  // once dy has been made positive.
  logic [PW-1:0]        s2_pa_r   [4];
  logic                 s2_nneg_r [4];
  logic [DW-1:0]        s2_d_r    [4];
  logic signed [CW-1:0] s2_xa_r   [4];
  // Stage 3: |2*num + den| and the sign of the quotient, ready for the divider.
  logic                 s3_neg_r [4];
  logic [PW-1:0]        s3_n_r   [4];
  logic [DW-1:0]        s3_d_r   [4];
  logic signed [CW-1:0] s3_xa_r  [4];
  logic signed [XEW-1:0] xc [4];

  for (genvar e = 0; e < 4; e++) begin : g_e2
    logic signed [2*CW+3:0] prod;
    logic [PW-1:0] pa;
    logic dneg;
    logic [DW-1:0] dpos;
    always_comb begin
      prod = (2*CW+4)'(s1_dyr_r[e]) * (2*CW+4)'(s1_dx_r[e]);
      pa = prod[2*CW+3] ? PW'(-prod) : PW'(prod);
      dneg = s1_dy_r[e][CW];
      dpos = dneg ? DW'(-s1_dy_r[e]) : DW'(s1_dy_r[e]);
    end
    always_ff @(posedge clk) begin
      s2_pa_r[e]   <= pa;
      s2_nneg_r[e] <= prod[2*CW+3] ^ dneg;
      s2_d_r[e]    <= dpos;
      s2_xa_r[e]   <= s1_xa_r[e];
    end
    // With a negative numerator, 2*num + den is den - 2|num|, whose sign
    // follows from comparing the two magnitudes.
    logic [PW-1:0] a2, dz, sum, dif_ad, dif_da;
    always_comb begin
      a2 = {s2_pa_r[e][PW-2:0], 1'b0};
      dz = PW'(s2_d_r[e]);
      sum = a2 + dz;
      dif_ad = a2 - dz;
      dif_da = dz - a2;
    end
    always_ff @(posedge clk) begin
      s3_d_r[e]  <= s2_d_r[e];
      s3_xa_r[e] <= s2_xa_r[e];
      if (!s2_nneg_r[e]) begin
        s3_n_r[e]   <= sum;
        s3_neg_r[e] <= 1'b0;
      end else if (a2 >= dz) begin
        s3_n_r[e]   <= dif_ad;
        s3_neg_r[e] <= 1'b1;
      end else begin
        s3_n_r[e]   <= dif_da;
        s3_neg_r[e] <= 1'b0;
      end
    end
    // Divisor is 2*|dy|; divide |t| by |dy| then halve (floor of floor).
    logic [PW-1:0] q;
    spf_div #(.NW(PW), .DW(DW)) u_div (
      .clk(clk), .num(s3_n_r[e]), .den(s3_d_r[e] == '0 ? DW'(1) : s3_d_r[e]), .quo(q)
    );
    logic                 neg_d [DL+1];
    logic signed [CW-1:0] xa_d  [DL+1];
    always_comb begin
      neg_d[0] = s3_neg_r[e];
      xa_d[0]  = s3_xa_r[e];
    end
    for (genvar k = 0; k < DL; k++) begin : g_dl
      logic nr; logic signed [CW-1:0] xr;
      always_ff @(posedge clk) begin
        nr <= neg_d[k];
        xr <= xa_d[k];
      end
      assign neg_d[k+1] = nr;
      assign xa_d[k+1]  = xr;
    end
    logic [PW-1:0] qh;
    logic signed [XEW-1:0] qs;
    assign qh = q >> 1;
    assign qs = neg_d[DL] ? -$signed(XEW'(qh)) : $signed(XEW'(qh));
    assign xc[e] = qs + XEW'(xa_d[DL]);
  end

  // The valid bit and the crossing flags travel beside the divider.
  logic [4:0] hv_d [HD+1];
  assign hv_d[0] = {s1_v_r, s1_hit_r};
  for (genvar k = 0; k < HD; k++) begin : g_vd
    logic [4:0] hv_r;
    always_ff @(posedge clk) begin
      if (!rst_n) hv_r <= '0;
      else hv_r <= hv_d[k];
    end
    assign hv_d[k+1] = hv_r;
  end

  // Stage 4: crossings of hit edges; the other slots get the largest value so
  // that they sort to the end, and the count says how many are real.
  logic [3:0]            hit4;
  logic                  v4;
  logic                  s4_v_r;
  logic [2:0]            s4_m_r;
  logic signed [XEW-1:0] s4_x_r [4];
  assign {v4, hit4} = hv_d[HD];
  always_ff @(posedge clk) begin
    for (int a = 0; a < 4; a++) s4_x_r[a] <= hit4[a] ? xc[a] : XFILL;
    s4_m_r <= 3'(hit4[0]) + 3'(hit4[1]) + 3'(hit4[2]) + 3'(hit4[3]);
    if (!rst_n) s4_v_r <= 1'b0;
    else s4_v_r <= v4;
  end

  // Stages 5 and 6: a four-input sorting network, two layers then one.
  logic                  s5_v_r;
  logic [2:0]            s5_m_r;
  logic signed [XEW-1:0] s5_x_r [4];
  logic signed [XEW-1:0] l1 [4];
  logic signed [XEW-1:0] l2 [4];
  always_comb begin
    l1 = s4_x_r;
    if (s4_x_r[0] > s4_x_r[1]) begin
      l1[0] = s4_x_r[1];
      l1[1] = s4_x_r[0];
    end
    if (s4_x_r[2] > s4_x_r[3]) begin
      l1[2] = s4_x_r[3];
      l1[3] = s4_x_r[2];
    end
    l2 = l1;
    if (l1[0] > l1[2]) begin
      l2[0] = l1[2];
      l2[2] = l1[0];
    end
    if (l1[1] > l1[3]) begin
      l2[1] = l1[3];
      l2[3] = l1[1];
    end
  end
  always_ff @(posedge clk) begin
    s5_m_r <= s4_m_r;
    s5_x_r <= l2;
    if (!rst_n) s5_v_r <= 1'b0;
    else s5_v_r <= s4_v_r;
  end

  logic                  s6_v_r;
  logic [2:0]            s6_m_r;
  logic signed [XEW-1:0] s6_x_r [4];
  logic signed [XEW-1:0] l3 [4];
  always_comb begin
    l3 = s5_x_r;
    if (s5_x_r[1] > s5_x_r[2]) begin
      l3[1] = s5_x_r[2];
      l3[2] = s5_x_r[1];
    end
  end
  always_ff @(posedge clk) begin
    s6_m_r <= s5_m_r;
    s6_x_r <= l3;
    if (!rst_n) s6_v_r <= 1'b0;
    else s6_v_r <= s5_v_r;
  end

  // Final stage: clamp and register the result.
  function automatic logic [24:0] span(input logic signed [XEW-1:0] a,
                                       input logic signed [XEW-1:0] b,
                                       input logic [11:0] clip);
    logic signed [XEW-1:0] ca, cb;
    begin
      ca = (a < 0) ? '0 : a;
      cb = (b > $signed(XEW'(clip))) ? $signed(XEW'(clip)) : b;
      if (ca <= cb) span = {1'b1, ca[11:0], cb[11:0]};
      else span = '0;
    end
  endfunction
  logic [24:0] sp0, sp1;
  always_comb begin
    sp0 = (s6_m_r >= 3'd2) ? span(s6_x_r[0], s6_x_r[1], clip_r) : '0;
    sp1 = (s6_m_r >= 3'd4) ? span(s6_x_r[2], s6_x_r[3], clip_r) : '0;
  end
  always_ff @(posedge clk) begin
    {out_first_span_valid, out_first_span_start, out_first_span_end} <= sp0;
    {out_second_span_valid, out_second_span_start, out_second_span_end} <= sp1;
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= s6_v_r;
  end

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_span_valid |-> out_first_span_start <= out_first_span_end)
    else $error("span start beyond end");
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_span_valid |-> out_second_span_end <= clip_r)
    else $error("span end beyond clip");
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    s6_v_r |-> s6_m_r == 3'd0 || s6_m_r == 3'd2 || s6_m_r == 3'd4)
    else $error("odd crossing count");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s6_v_r |=> out_valid) else $error("item lost");
endmodule

[bench/tb_scanline_polygon_span_fill.sv]
// Self-checking testbench for the scanline span fill block.
// Depends on spf_pkg and the scanline_polygon_span_fill RTL.
`timescale 1ns / 1ps

module tb_scanline_polygon_span_fill;

  localparam int CB = 16;
  localparam int LAT = 2 * CB + 9;

  // One span answer for a row: two inclusive spans.
  typedef struct packed {
    logic                   v1;
    logic [spf_pkg::XW-1:0] s1;
    logic [spf_pkg::XW-1:0] e1;
    logic                   v2;
    logic [spf_pkg::XW-1:0] s2;
    logic [spf_pkg::XW-1:0] e2;
  } spans_t;

  // One polygon query for a row.
  typedef struct {
    logic signed [CB-1:0] vx[4];
    logic signed [CB-1:0] vy[4];
    logic [2:0]           corners;
    logic [11:0]          row;
  } query_t;

  // A directed row: the query, and a typed-in answer where one is known.
  typedef struct {
    query_t q;
    logic   known;
    spans_t ans;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] v0x = '0, v0y = '0, v1x = '0, v1y = '0;
  logic signed [CB-1:0] v2x = '0, v2y = '0, v3x = '0, v3y = '0;
  logic [2:0]  corners = 3'd3;
  logic [11:0] row = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_clip = '0;
  logic        out_valid;
  logic        o_v1, o_v2;
  logic [11:0] o_s1, o_e1, o_s2, o_e2;

  // The clip edge as the bench believes the block holds it.
  logic [11:0] clip_model;
  spans_t      span_queue[$];
  int          mismatches = 0;
  int          sender_idle_pct = 0;

  scanline_polygon_span_fill #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vertex0_x(v0x), .in_vertex0_y(v0y), .in_vertex1_x(v1x), .in_vertex1_y(v1y),
    .in_vertex2_x(v2x), .in_vertex2_y(v2y), .in_vertex3_x(v3x), .in_vertex3_y(v3y),
    .in_corner_count(corners), .in_row(row),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_clip_right_edge(cfg_clip),
    .out_valid(out_valid),
    .out_first_span_valid(o_v1), .out_first_span_start(o_s1), .out_first_span_end(o_e1),
    .out_second_span_valid(o_v2), .out_second_span_start(o_s2),
    .out_second_span_end(o_e2)
  );

  always #6 clk = ~clk;

  // Clamps one pair of crossings to the screen and the clip edge. A pair whose
  // clamped start lies right of its clamped end gives an empty span, all zero.
  function automatic void clamp_span(input longint a, input longint b,
                                     input logic [11:0] clip, output logic v,
                                     output logic [11:0] s, output logic [11:0] e);
    longint lim;
    lim = longint'(clip);
    if (a < 0) a = 0;
    if (b > lim) b = lim;
    v = (a <= b);
    s = v ? a[11:0] : '0;
    e = v ? b[11:0] : '0;
  endfunction

  // Computes the spans of a row under the even-odd rule. The crossing x is
  // the rounded rational (2*num + den) / (2*den), with den made positive and
  // the quotient truncated toward zero, as the hardware divider does it.
  function automatic spans_t fill_row(input query_t q, input logic [11:0] clip);
    spans_t r;
    longint xs[4];
    longint xa, ya, xb, yb, y, num, den, t;
    int n, m, j, p;
    r = '0;
    m = 0;
    y = longint'(q.row);
    n = (q.corners >= 3'd4) ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      j = (i == 0) ? n - 1 : i - 1;
      xa = q.vx[j]; ya = q.vy[j]; xb = q.vx[i]; yb = q.vy[i];
      if ((ya <= y) != (yb <= y)) begin
        num = (y - ya) * (xb - xa);
        den = yb - ya;
        if (den < 0) begin
          num = -num;
          den = -den;
        end
        xs[m] = xa + (2 * num + den) / (2 * den);
        m++;
      end
    end
    // Insertion sort of at most four crossings.
    for (int i = 1; i < m; i++) begin
      t = xs[i];
      p = i - 1;
      while (p >= 0 && xs[p] > t) begin
        xs[p + 1] = xs[p];
        p--;
      end
      xs[p + 1] = t;
    end
    if (m >= 2) clamp_span(xs[0], xs[1], clip, r.v1, r.s1, r.e1);
    if (m >= 4) clamp_span(xs[2], xs[3], clip, r.v2, r.s2, r.e2);
    return r;
  endfunction

  function automatic query_t make_query(input int ax, ay, bx, by, cx, cy, dx, dy,
                                        input int k, input int r);
    query_t q;
    q.vx[0] = CB'(ax); q.vy[0] = CB'(ay); q.vx[1] = CB'(bx); q.vy[1] = CB'(by);
    q.vx[2] = CB'(cx); q.vy[2] = CB'(cy); q.vx[3] = CB'(dx); q.vy[3] = CB'(dy);
    q.corners = k[2:0];
    q.row = r[11:0];
    return q;
  endfunction

  // Random query. Mostly small polygons lying around the asked row so that
  // crossings and spans do occur; sometimes full-range noise on a vertex or on the corner count.
  function automatic query_t random_query();
    query_t q;
    int r, spread;
    r = int'($urandom_range(0, 4095));
    spread = ($urandom_range(0, 3) == 0) ? 3000 : 200;
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        q.vx[i] = CB'($urandom);
        q.vy[i] = CB'($urandom);
      end else begin
        q.vx[i] = CB'(int'($urandom_range(0, 2 * spread + 1300)) - spread);
        q.vy[i] = CB'(r + int'($urandom_range(0, 2 * spread)) - spread);
      end
    end
    q.corners = ($urandom_range(0, 4) == 0) ? 3'($urandom) :
                ($urandom_range(0, 1) ? 3'd4 : 3'd3);
    q.row = r[11:0];
    return q;
  endfunction

  // Drives one item and holds it until it is taken; the expected spans are
  // queued at the accepting edge. Start stays high from item to item when no
  // idle cycle falls between them.
  task automatic send_query(input query_t q, input logic known, input spans_t ans);
    spans_t exp_spans;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    v0x <= q.vx[0]; v0y <= q.vy[0]; v1x <= q.vx[1]; v1y <= q.vy[1];
    v2x <= q.vx[2]; v2y <= q.vy[2]; v3x <= q.vx[3]; v3y <= q.vy[3];
    corners <= q.corners;
    row <= q.row;
    start <= 1'b1;
    exp_spans = known ? ans : fill_row(q, clip_model);
    @(posedge clk);
    while (busy) @(posedge clk);
    span_queue.push_back(exp_spans);
  endtask

  // Waits until every expected result is in, lowering start first.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (span_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the clip edge while the pipeline is empty.
  task automatic write_clip(input logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_clip <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    clip_model = value;
  endtask

  // Result checker: each strobed result is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (span_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        spans_t e, got;
        e = span_queue.pop_front();
        got = '{o_v1, o_s1, o_e1, o_v2, o_s2, o_e2};
        if (got !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"span mismatch at %0t: exp %0b %0d..%0d %0b %0d..%0d",
                      " got %0b %0d..%0d %0b %0d..%0d"},
                     $realtime, e.v1, e.s1, e.e1, e.v2, e.s2, e.e2,
                     got.v1, got.s1, got.e1, got.v2, got.s2, got.e2);
        end
      end
    end
  end

  initial begin
    #(12ns * 400000);
    $display("[scanline_polygon_span_fill] ERROR");
    $finish;
  end

  initial begin
    dir_row_t dir_rows[$];
    dir_row_t d;
    int phase_idle[4] = '{0, 75, 0, 29};
    logic [11:0] clips[4] = '{12'd4095, 12'd0, 12'd640, 12'd1263};

    clip_model = spf_pkg::CLIP_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Typed answers are those that can be read off by eye;
    // the rest go through the predictor at the reset clip edge.
    // Triangle whose row misses every edge: no crossings, both spans empty.
    d.q = make_query(0, 0, 10, 0, 5, 5, 0, 0, 3, 100); d.known = 1; d.ans = '0;
    dir_rows.push_back(d);
    // Square 10..20 around row 15: one span, 10..20.
    d.q = make_query(10, 10, 20, 10, 20, 20, 10, 20, 4, 15); d.known = 1;
    d.ans = '{1'b1, 12'd10, 12'd20, 1'b0, 12'd0, 12'd0};
    dir_rows.push_back(d);
    // Same square fully left of the screen: the span is empty after clamping.
    d.q = make_query(-30, 10, -20, 10, -20, 20, -30, 20, 4, 15); d.known = 1; d.ans = '0;
    dir_rows.push_back(d);
    // Square right of the clip edge: empty.
    d.q = make_query(2000, 10, 2100, 10, 2100, 20, 2000, 20, 4, 15); d.known = 1;
    d.ans = '0;
    dir_rows.push_back(d);
    // Huge square covering the screen: clamped to 0..reset clip edge.
    d.q = make_query(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767, 4, 0);
    d.known = 1; d.ans = '{1'b1, 12'd0, spf_pkg::CLIP_RESET, 1'b0, 12'd0, 12'd0};
    dir_rows.push_back(d);
    d.known = 0; d.ans = '0;
    // Concave quad giving two spans, and the same with other corner counts.
    d.q = make_query(0, 0, 50, 40, 100, 0, 50, 100, 4, 20); dir_rows.push_back(d);
    d.q = make_query(0, 0, 50, 40, 100, 0, 50, 100, 7, 20); dir_rows.push_back(d);
    d.q = make_query(0, 0, 50, 40, 100, 0, 50, 100, 0, 20); dir_rows.push_back(d);
    d.q = make_query(0, 0, 50, 40, 100, 0, 50, 100, 3, 20); dir_rows.push_back(d);
    // Horizontal edges on the row itself, at the bottom and at the top.
    d.q = make_query(5, 30, 60, 30, 30, 90, 0, 0, 3, 30); dir_rows.push_back(d);
    d.q = make_query(5, 30, 60, 30, 30, 0, 0, 0, 3, 30); dir_rows.push_back(d);
    // Extreme slopes and rounding at one half, negative dx.
    d.q = make_query(32767, -32768, -32768, 32767, 0, 32767, 0, 0, 3, 4095);
    dir_rows.push_back(d);
    d.q = make_query(-32768, 4095, 32767, 0, 1, 1, 0, 0, 3, 2048); dir_rows.push_back(d);
    d.q = make_query(3, 0, 0, 2, 9, 2, 0, 0, 3, 1); dir_rows.push_back(d);
    d.q = make_query(-1, -1, -1, 32767, 4095, 32767, 4095, -1, 4, 4095);
    dir_rows.push_back(d);
    d.q = make_query(-21846, 21845, 21845, -21846, -1, -1, 1, 1, 4, 2730);
    dir_rows.push_back(d);
    foreach (dir_rows[i]) send_query(dir_rows[i].q, dir_rows[i].known, dir_rows[i].ans);
    // The sender holds off here until every result has come back.
    drain();
    repeat (LAT) @(posedge clk);

    // Random phases, each under its own clip edge and idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      write_clip(clips[ph]);
      sender_idle_pct = phase_idle[ph];
      for (int k = 0; k < 485; k++) begin
        // Stretches without idling inside the idle phases.
        if (phase_idle[ph] != 0) sender_idle_pct = ((k / 60) % 3 == 2) ? 0 : phase_idle[ph];
        send_query(random_query(), 1'b0, '0);
      end
      drain();
      repeat (LAT) @(posedge clk);
    end

    if (mismatches == 0 && span_queue.size() == 0)
      $display("[scanline_polygon_span_fill] OK");
    else
      $display("[scanline_polygon_span_fill] ERROR");
    $finish;
  end

endmodule
